FILE: design/b64d_pkg.sv
// ----------------------------------------------------------------------------
// Base64 decoder package
// Types and constants shared by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_PAD  = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    // One queued command: up to three results that share a source group.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  nres;
        logic        data;
        logic        eos;
        logic        err;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_head;

endpackage

FILE: design/b64d_front.sv
// ----------------------------------------------------------------------------
// Base64 decoder front end
// Classifies each character, tracks the group state and issues commands.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_strict_we,
    input  logic           i_strict_mode,
    input  logic           i_accept,
    input  logic [7:0]     i_char_code,
    input  logic           i_last_char,
    output logic           o_push,
    output b64d_pkg::t_cmd o_cmd
);
    import b64d_pkg::*;

    logic        r_strict;
    logic [17:0] r_acc;
    logic [1:0]  r_pos;
    logic [1:0]  r_pad;
    logic        r_err;

    logic [17:0] n_acc;
    logic [1:0]  n_pos;
    logic [1:0]  n_pad;
    logic        n_err;

    t_kind       kind;
    logic [5:0]  sextet;
    logic [23:0] v;
    logic [23:0] v24;
    logic [2:0]  n;
    logic [2:0]  p;
    logic [2:0]  d;
    logic [1:0]  nb;
    logic        push;
    t_cmd        cmd;

    always_comb begin
        kind   = KIND_DATA;
        sextet = 6'd0;
        if (i_char_code >= 8'h41 && i_char_code <= 8'h5A) begin
            sextet = 6'(i_char_code - 8'h41);
        end else if (i_char_code >= 8'h61 && i_char_code <= 8'h7A) begin
            sextet = 6'(i_char_code - 8'h61 + 8'd26);
        end else if (i_char_code >= 8'h30 && i_char_code <= 8'h39) begin
            sextet = 6'(i_char_code - 8'h30 + 8'd52);
        end else if (i_char_code == 8'h2B) begin
            sextet = 6'd62;
        end else if (i_char_code == 8'h2F) begin
            sextet = 6'd63;
        end else if (i_char_code == PAD_CHAR) begin
            kind = KIND_PAD;
        end else begin
            kind = KIND_BAD;
        end
    end

    always_comb begin
        n_acc = r_acc;
        n_pos = r_pos;
        n_pad = r_pad;
        n_err = r_err;
        push  = 1'b0;
        cmd   = '0;
        v     = {r_acc, sextet};
        n     = {1'b0, r_pos} + 3'd1;
        p     = 3'd0;
        d     = 3'd0;
        nb    = 2'd0;
        v24   = v;

        if (r_err) begin
            if (i_last_char) begin
                n_acc = '0;
                n_pos = '0;
                n_pad = '0;
                n_err = 1'b0;
            end
        end else if (r_strict && (kind == KIND_BAD ||
                                  (kind == KIND_DATA && r_pad != 2'd0))) begin
            n_acc    = '0;
            n_pos    = '0;
            n_pad    = '0;
            n_err    = ~i_last_char;
            push     = 1'b1;
            cmd.nres = 2'd1;
            cmd.eos  = i_last_char;
            cmd.err  = 1'b1;
        end else begin
            if (kind == KIND_PAD) begin
                if (r_pad != 2'd3) begin
                    n_pad = r_pad + 2'd1;
                end
            end else begin
                n_pad = 2'd0;
            end

            if (!i_last_char) begin
                if (n == 3'd4) begin
                    push      = 1'b1;
                    cmd.bytes = v;
                    cmd.nres  = 2'd3;
                    cmd.data  = 1'b1;
                    n_acc     = '0;
                    n_pos     = '0;
                end else begin
                    n_acc = v[17:0];
                    n_pos = n[1:0];
                end
            end else begin
                p  = ({1'b0, n_pad} < n) ? {1'b0, n_pad} : n;
                d  = n - p;
                nb = (d != 3'd0) ? 2'(d - 3'd1) : 2'd0;
                case (n)
                    3'd1:    v24 = {v[5:0], 18'd0};
                    3'd2:    v24 = {v[11:0], 12'd0};
                    3'd3:    v24 = {v[17:0], 6'd0};
                    default: v24 = v;
                endcase
                n_acc   = '0;
                n_pos   = '0;
                n_pad   = '0;
                n_err   = 1'b0;
                push    = 1'b1;
                cmd.eos = 1'b1;
                if (nb == 2'd0) begin
                    cmd.nres = 2'd1;
                end else begin
                    cmd.bytes = v24;
                    cmd.nres  = nb;
                    cmd.data  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
            r_acc    <= '0;
            r_pos    <= '0;
            r_pad    <= '0;
            r_err    <= 1'b0;
        end else begin
            if (i_strict_we) begin
                r_strict <= i_strict_mode;
            end
            if (i_accept) begin
                r_acc <= n_acc;
                r_pos <= n_pos;
                r_pad <= n_pad;
                r_err <= n_err;
            end
        end
    end

    assign o_push = i_accept & push;
    assign o_cmd  = cmd;

endmodule

FILE: design/b64d_queue.sv
// ----------------------------------------------------------------------------
// Base64 decoder command queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output b64d_pkg::t_head o_head
);
    import b64d_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    logic do_pop;

    assign o_full       = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_pop       = i_pop & o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/b64d_back.sv
// ----------------------------------------------------------------------------
// Base64 decoder back end
// Splits each queued command into result beats held in an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b64d_pkg::t_head i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_string,
    output logic            o_decode_error
);
    import b64d_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_bval;
    logic       r_eos;
    logic       r_err;

    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = i_head.valid & (~r_valid | ~i_stall);
    assign at_end = (r_idx == i_head.cmd.nres - 2'd1);
    assign o_pop  = load & at_end;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.cmd.bytes[23:16];
            2'd1:    sel_byte = i_head.cmd.bytes[15:8];
            default: sel_byte = i_head.cmd.bytes[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.cmd.data ? sel_byte : 8'd0;
            r_bval <= i_head.cmd.data;
            r_eos  <= i_head.cmd.eos & at_end;
            r_err  <= i_head.cmd.err;
        end
    end

    assign o_valid         = r_valid;
    assign o_data_byte     = r_byte;
    assign o_byte_valid    = r_bval;
    assign o_end_of_string = r_eos;
    assign o_decode_error  = r_err;

endmodule

FILE: design/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// Base64 stream decoder
// Decodes one base64 character per beat into bytes, with optional strict checking.
//
//   Channel   Handshake            Payload
//   input     i_valid / o_stall    i_char_code, i_last_char
//   output    o_valid / i_stall    o_data_byte, o_byte_valid,
//                                  o_end_of_string, o_decode_error
//   config    i_strict_we          i_strict_mode
//
// One character is taken every cycle while o_stall is low; a full group
// of four gives three byte beats, sent one per cycle from the back end's
// output register while i_stall is low. A four-entry command queue
// separates the character and result sides, and o_stall rises only while
// that queue is full. Reset is synchronous.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_strict_we,
    input  logic       i_strict_mode,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_string,
    output logic       o_decode_error
);
    import b64d_pkg::*;

    logic  accept;
    logic  push;
    logic  pop;
    logic  full;
    t_cmd  cmd;
    t_head head;

    assign o_stall = full;
    assign accept  = i_valid & ~full;

    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_strict_we   (i_strict_we),
        .i_strict_mode (i_strict_mode),
        .i_accept      (accept),
        .i_char_code   (i_char_code),
        .i_last_char   (i_last_char),
        .o_push        (push),
        .o_cmd         (cmd)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    b64d_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_decode_error  (o_decode_error)
    );

endmodule

FILE: tb/tb_base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base64 stream decoder testbench
// Sends base64 strings one character per beat and rebuilds every decoded
// byte, end marker and strict-mode error in a local decoder model. Each
// output beat is checked in order against that model. The run covers both
// modes, directed corner strings, random well-formed and broken strings,
// random idling on both channels, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;

    import b64d_pkg::*;

    localparam int IDLE_PCT    = 18;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int STUCK_LIMIT = 1000;

    typedef logic [7:0] t_char_q[$];

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       decode_error;
    } t_out_beat;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_strict_we     = 1'b0;
    logic       i_strict_mode   = 1'b0;
    logic       i_valid         = 1'b0;
    logic [7:0] i_char_code     = 8'h00;
    logic       i_last_char     = 1'b0;
    logic       i_stall         = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_data_byte;
    logic       o_byte_valid;
    logic       o_end_of_string;
    logic       o_decode_error;

    t_out_beat   expected_beats[$];
    logic [17:0] sextet_acc   = '0;
    int          group_fill   = 0;
    int          pad_run      = 0;
    logic        drop_rest    = 1'b0;
    logic        strict_on    = 1'b0;

    int tx_gap_pct     = IDLE_PCT;
    int rx_gap_pct     = IDLE_PCT;
    int hold_left      = 0;
    int chars_sent     = 0;
    int beats_seen     = 0;
    int error_beats    = 0;
    int marker_beats   = 0;
    int blocked_cycles = 0;
    int mismatches     = 0;
    int stuck          = 0;

    base64_stream_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_strict_we     (i_strict_we),
        .i_strict_mode   (i_strict_mode),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_code     (i_char_code),
        .i_last_char     (i_last_char),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .o_decode_error  (o_decode_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c, output t_kind kind);
        kind = KIND_DATA;
        if (c >= "A" && c <= "Z") return 6'(c - "A");
        if (c >= "a" && c <= "z") return 6'(c - "a" + 26);
        if (c >= "0" && c <= "9") return 6'(c - "0" + 52);
        if (c == "+") return 6'd62;
        if (c == "/") return 6'd63;
        kind = (c == PAD_CHAR) ? KIND_PAD : KIND_BAD;
        return 6'd0;
    endfunction

    function automatic logic [7:0] sextet_to_char(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        return (v == 62) ? 8'("+") : 8'("/");
    endfunction

    function automatic void push_beat(input logic [7:0] b, input logic bv, input logic eos,
                                      input logic err);
        expected_beats.push_back('{data_byte: b, byte_valid: bv, end_of_string: eos,
                                   decode_error: err});
        if (err) error_beats++;
        else if (!bv) marker_beats++;
    endfunction

    function automatic void clear_group();
        sextet_acc = '0;
        group_fill = 0;
        pad_run    = 0;
        drop_rest  = 1'b0;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic last);
        t_kind       kind;
        logic [5:0]  sextet;
        logic [23:0] grp;
        logic [23:0] aligned;
        int          n;
        int          pads;
        int          nbytes;
        if (drop_rest) begin
            if (last) clear_group();
            return;
        end
        sextet = char_to_sextet(c, kind);
        if (strict_on && (kind == KIND_BAD || (kind == KIND_DATA && pad_run != 0))) begin
            clear_group();
            drop_rest = !last;
            push_beat(8'h00, 1'b0, last, 1'b1);
            return;
        end
        if (kind == KIND_PAD) begin
            if (pad_run < 3) pad_run++;
        end else begin
            pad_run = 0;
        end
        grp = {sextet_acc, sextet};
        n   = group_fill + 1;
        if (!last) begin
            if (n == 4) begin
                push_beat(grp[23:16], 1'b1, 1'b0, 1'b0);
                push_beat(grp[15:8], 1'b1, 1'b0, 1'b0);
                push_beat(grp[7:0], 1'b1, 1'b0, 1'b0);
                sextet_acc = '0;
                group_fill = 0;
            end else begin
                sextet_acc = grp[17:0];
                group_fill = n;
            end
            return;
        end
        pads    = (pad_run < n) ? pad_run : n;
        nbytes  = (n - pads > 0) ? n - pads - 1 : 0;
        aligned = grp << (6 * (4 - n));
        clear_group();
        if (nbytes == 0) begin
            push_beat(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
            for (int i = 0; i < nbytes; i++) begin
                push_beat(aligned[23 - 8 * i -: 8], 1'b1, i + 1 == nbytes, 1'b0);
            end
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("MISMATCH at beat %0d, %s: got 0x%0h, expected 0x%0h",
                     beats_seen, field, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_valid && o_stall) blocked_cycles++;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", o_data_byte, 0);
            end else begin
                want = expected_beats.pop_front();
                if (o_data_byte !== want.data_byte)
                    report_mismatch("data_byte", o_data_byte, want.data_byte);
                if (o_byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                if (o_end_of_string !== want.end_of_string)
                    report_mismatch("end_of_string", o_end_of_string, want.end_of_string);
                if (o_decode_error !== want.decode_error)
                    report_mismatch("decode_error", o_decode_error, want.decode_error);
            end
            beats_seen++;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_gap_pct);
            end
        end
    end

    initial begin
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) stuck = 0;
            else stuck++;
        end
        $display("Timeout: no handshake for %0d cycles, %0d beats still expected",
                 STUCK_LIMIT, expected_beats.size());
        $display("Verification failed");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (o_stall);
        decode_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    task automatic send_chars(input t_char_q txt);
        for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_strict(input logic mode);
        wait_for_results();
        i_strict_we   <= 1'b1;
        i_strict_mode <= mode;
        @(posedge i_clk);
        i_strict_we   <= 1'b0;
        strict_on = mode;
    endtask

    task automatic make_text(output t_char_q txt);
        int nbytes;
        int rem;
        int pos;
        txt = {};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
        rem    = nbytes % 3;
        repeat (nbytes / 3) repeat (4) txt.push_back(sextet_to_char($urandom_range(0, 63)));
        if (rem != 0) begin
            repeat (rem + 1) txt.push_back(sextet_to_char($urandom_range(0, 63)));
            if ($urandom_range(0, 1)) repeat (3 - rem) txt.push_back(PAD_CHAR);
        end
        if (txt.size() == 0) begin
            if ($urandom_range(0, 1)) txt.push_back(sextet_to_char($urandom_range(0, 63)));
            else repeat ($urandom_range(1, 4)) txt.push_back(PAD_CHAR);
        end
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, txt.size() - 1);
            txt[pos] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
        end
    endtask

    task automatic test_lenient_cases();
        send_text("Q");
        send_text("TQ==TWFu");
        send_char(8'h00, 1'b0);
        send_char(PAD_CHAR, 1'b0);
        send_char("/", 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("AAAA");
    endtask

    task automatic test_strict_cases();
        send_text("Zg==");
        send_text("a*bc");
        send_text("=");
        send_text("A=B");
    endtask

    task automatic test_random_strings(input int n_chars);
        t_char_q txt;
        int      goal;
        goal = chars_sent + n_chars;
        while (chars_sent < goal) begin
            make_text(txt);
            send_chars(txt);
        end
    endtask

    task automatic test_receiver_holdoff();
        tx_gap_pct = 0;
        hold_left  = HOLD_CYCLES;
        repeat (8) send_text("TWFu");
        send_char("Z", 1'b0);
        send_char("m", 1'b0);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_beats.size() != 0);
        send_char("9", 1'b0);
        send_char("v", 1'b1);
        tx_gap_pct = IDLE_PCT;
    endtask

    task automatic test_no_idle_stretch(input int n_chars);
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        test_random_strings(n_chars);
        tx_gap_pct = IDLE_PCT;
        rx_gap_pct = IDLE_PCT;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_strict(1'b0);
        test_lenient_cases();
        set_strict(1'b1);
        test_strict_cases();
        test_random_strings(150);
        set_strict(1'b0);
        test_random_strings(150);
        set_strict(1'b1);
        test_receiver_holdoff();
        test_no_idle_stretch(100);
        set_strict(1'b0);
        test_random_strings(100);
        wait_for_results();
        $display("Sent %0d characters in strict and lenient modes; checked %0d output beats.",
                 chars_sent, beats_seen);
        $display("Saw %0d strict errors, %0d empty end markers, input held off for %0d cycles.",
                 error_beats, marker_beats, blocked_cycles);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
